@@ hdl/cll_pkg.sv @@
// shared types and constants for the circular list with cursor
package cll_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      CMD_INS_HEAD = 3'd0,
      CMD_INS_TAIL = 3'd1,
      CMD_FIRST    = 3'd2,
      CMD_NEXT     = 3'd3,
      CMD_REMOVE   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_NOCUR = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] data;
      status_type                   status;
      logic [CNT_W-1:0]             count;
   } rsp_type;

endpackage

@@ hdl/circular_list_with_cursor.sv @@
// circular singly linked list with cursor over a fixed node pool
// Each command word is taken while req_stall is low and its result word is registered onto the rsp
// channel; a new command can be accepted in every cycle while req_stall is low, as the whole pointer
// update (one next-pointer lookup, one data lookup and the splice) is done combinationally between
// the request and the result register. A two-word output queue lets one further command be
// accepted while a result is still stalled; req_stall rises only when both words are held.
// Reset is synchronous; the free list is rebuilt by it at once.
module circular_list_with_cursor
   import cll_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_cmd,
   input  logic signed [DATA_WIDTH-1:0] req_data_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_data_out,
   output logic [1:0]                   rsp_status,
   output logic [CNT_W-1:0]             rsp_count
);

   logic signed [DATA_WIDTH-1:0] node_data_ff [CAPACITY];
   logic [IDX_W-1:0]             node_next_ff [CAPACITY];
   logic [IDX_W-1:0]             node_next_in [CAPACITY];

   logic [IDX_W-1:0] free_head_ff, free_head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic [IDX_W-1:0] before_ff, before_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [CNT_W-1:0] count_ff, count_in;

   rsp_type out_ff, skid_ff, res;
   logic    out_valid_ff, skid_valid_ff;

   cmd_type          cmd;
   logic             accept;
   logic             out_take;
   logic [IDX_W-1:0] look_addr;
   logic [IDX_W-1:0] look_next;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_en;
   logic             wr_en;

   assign cmd      = cmd_type'(req_cmd);
   assign req_stall = skid_valid_ff;
   assign accept   = req_valid && !skid_valid_ff;
   assign out_take = out_valid_ff && !rsp_stall;

   // one pointer lookup per command: free head for inserts, cursor otherwise
   assign look_addr = (cmd == CMD_INS_HEAD || cmd == CMD_INS_TAIL) ? free_head_ff : cursor_ff;
   assign look_next = node_next_ff[look_addr];

   always_comb begin
      node_next_in = node_next_ff;
      free_head_in = free_head_ff;
      tail_in      = tail_ff;
      head_in      = head_ff;
      cursor_in    = cursor_ff;
      before_in    = before_ff;
      cur_valid_in = cur_valid_ff;
      count_in     = count_ff;
      res.status   = ST_OK;
      rd_addr      = head_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      if (accept) begin
         case (cmd) inside
            CMD_INS_HEAD, CMD_INS_TAIL: begin
               if (count_ff >= CNT_W'(CAPACITY)) begin
                  res.status = ST_FULL;
               end else begin
                  wr_en        = 1'b1;
                  free_head_in = look_next;
                  if (count_ff == '0) begin
                     node_next_in[free_head_ff] = free_head_ff;
                     tail_in                    = free_head_ff;
                     head_in                    = free_head_ff;
                  end else begin
                     node_next_in[free_head_ff] = head_ff;
                     node_next_in[tail_ff]      = free_head_ff;
                     if (cmd == CMD_INS_TAIL) begin
                        tail_in = free_head_ff;
                     end else begin
                        head_in = free_head_ff;
                     end
                  end
                  count_in     = count_ff + CNT_W'(1);
                  cur_valid_in = 1'b0;
               end
            end
            CMD_FIRST: begin
               if (count_ff == '0) begin
                  res.status = ST_EMPTY;
               end else begin
                  before_in    = tail_ff;
                  cursor_in    = head_ff;
                  cur_valid_in = 1'b1;
                  rd_addr      = head_ff;
                  rd_en        = 1'b1;
               end
            end
            CMD_NEXT: begin
               if (count_ff == '0) begin
                  res.status = ST_EMPTY;
               end else if (!cur_valid_ff) begin
                  res.status = ST_NOCUR;
               end else begin
                  before_in = cursor_ff;
                  cursor_in = look_next;
                  rd_addr   = look_next;
                  rd_en     = 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (count_ff == '0) begin
                  res.status = ST_EMPTY;
               end else if (!cur_valid_ff ||
                            (count_ff >= CNT_W'(2) && cursor_ff == before_ff)) begin
                  res.status = ST_NOCUR;
               end else begin
                  rd_addr = cursor_ff;
                  rd_en   = 1'b1;
                  if (count_ff == CNT_W'(1)) begin
                     tail_in      = '0;
                     cursor_in    = '0;
                     before_in    = '0;
                     cur_valid_in = 1'b0;
                  end else begin
                     if (cursor_ff == tail_ff) begin
                        tail_in = before_ff;
                     end
                     if (cursor_ff == head_ff) begin
                        head_in = look_next;
                     end
                     node_next_in[before_ff] = look_next;
                     cursor_in               = before_ff;
                  end
                  node_next_in[cursor_ff] = free_head_ff;
                  free_head_in            = cursor_ff;
                  count_in                = count_ff - CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
      res.data  = rd_en ? node_data_ff[rd_addr] : '0;
      res.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_data_ff[free_head_ff] <= req_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) begin
            node_next_ff[i] <= (i + 1 < CAPACITY) ? IDX_W'(i + 1) : '0;
         end
         free_head_ff  <= '0;
         tail_ff       <= '0;
         head_ff       <= '0;
         cursor_ff     <= '0;
         before_ff     <= '0;
         cur_valid_ff  <= 1'b0;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         node_next_ff <= node_next_in;
         free_head_ff <= free_head_in;
         tail_ff      <= tail_in;
         head_ff      <= head_in;
         cursor_ff    <= cursor_in;
         before_ff    <= before_in;
         cur_valid_ff <= cur_valid_in;
         count_ff     <= count_in;
         // two-word result queue
         if (skid_valid_ff) begin
            if (out_take) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (!out_valid_ff || out_take) begin
               out_ff       <= res;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= res;
               skid_valid_ff <= 1'b1;
            end
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_data_out = out_ff.data;
   assign rsp_status   = out_ff.status;
   assign rsp_count    = out_ff.count;

endmodule

@@ hdl/cll_checker.sv @@
// port-level checker for the circular list with cursor, bound to the top level
module cll_checker
   import cll_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [DATA_WIDTH-1:0] rsp_data_out,
   input logic [1:0]                   rsp_status,
   input logic [CNT_W-1:0]             rsp_count
);

   // a held result word keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out) &&
      $stable(rsp_status) && $stable(rsp_count))
      else $error("stalled result word changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= CNT_W'(CAPACITY))
      else $error("count beyond pool size");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count == CNT_W'(CAPACITY))
      else $error("pool full reported with free nodes");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0 && rsp_data_out == '0)
      else $error("list empty reported with stored nodes");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channel busy after reset");

endmodule

bind circular_list_with_cursor cll_checker u_cll_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_data_out (rsp_data_out),
   .rsp_status   (rsp_status),
   .rsp_count    (rsp_count)
);
